/* rtl/core/cqs_pkg.sv */
// Shared types, constants and index helper for the circular queue with search.
package cqs_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int WORD_W = 32;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [WORD_W-1:0] data_value;
  } cqs_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] data_out;
    logic                     found;
  } cqs_out_t;

  function automatic idx_t advance(input idx_t i);
    idx_t r;
    if (i == idx_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

endpackage

/* rtl/core/cqs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/circular_queue_with_search.sv */
// Top level: circular FIFO of signed words with insert, delete and search requests.
//
// Usage:
//   A transaction is accepted at a rising edge where start is high and busy is low.
//   in_item carries req_type (insert, delete, search) and data_value.
//   Exactly one result per transaction appears on out_item for one cycle with
//   out_valid high; the receiver cannot stall, so it must take it then.
//   Capacity is DEPTH-1 words; one slot always stays empty.
// Timing:
//   Insert and unused codes: result the cycle after accept, busy never rises.
//   Delete: the registered RAM read completes in S_DEL, then the result is registered.
//   Search on a non-empty queue: S_SRCH examines up to DEPTH-1 entries from the oldest
//   on until a match or the tail, the single RAM read port walked one slot per cycle.
//   A full or empty result always comes the cycle after accept.
// Reset:
//   Synchronous active-low rst_n empties the queue and returns to idle; slot
//   contents are not cleared and need no clearing pass.
module circular_queue_with_search
  import cqs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  cqs_in_t  in_item,
  output logic     out_valid,
  output cqs_out_t out_item
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_SRCH
  } state_t;

  state_t   state_r, state_nxt;
  idx_t     head_r, head_nxt;
  idx_t     tail_r, tail_nxt;
  idx_t     idx_r, idx_nxt;
  logic signed [WORD_W-1:0] value_r, value_nxt;
  logic     out_valid_r, out_valid_nxt;
  cqs_out_t out_item_r, out_item_nxt;

  logic              ram_we;
  idx_t              ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  idx_t              ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              empty;

  cqs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign empty     = (head_r == tail_r);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    idx_nxt       = idx_r;
    value_nxt     = value_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = advance(tail_r);
    ram_wdata     = in_item.data_value;
    ram_raddr     = advance(head_r);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_item_nxt.status   = ST_OK;
          out_item_nxt.data_out = '0;
          out_item_nxt.found    = 1'b0;
          case (in_item.req_type)
            REQ_INSERT: begin
              out_valid_nxt = 1'b1;
              if (advance(tail_r) == head_r) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                ram_we   = 1'b1;
                tail_nxt = advance(tail_r);
              end
            end
            REQ_DELETE: begin
              if (empty) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = ST_EMPTY;
              end else begin
                head_nxt  = advance(head_r);
                state_nxt = S_DEL;
              end
            end
            REQ_SEARCH: begin
              if (empty) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = ST_EMPTY;
              end else begin
                idx_nxt   = advance(head_r);
                value_nxt = in_item.data_value;
                state_nxt = S_SRCH;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_DEL: begin
        out_valid_nxt         = 1'b1;
        out_item_nxt.data_out = ram_rdata;
        state_nxt             = S_IDLE;
      end
      S_SRCH: begin
        ram_raddr = advance(idx_r);
        if (ram_rdata == value_r) begin
          out_valid_nxt      = 1'b1;
          out_item_nxt.found = 1'b1;
          state_nxt          = S_IDLE;
        end else if (idx_r == tail_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = advance(idx_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    value_r    <= value_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
